// ===== hw/rtl/stable_priority_queue_defines.svh =====
// Assertion macros for the stable priority queue.
`ifndef STABLE_PRIORITY_QUEUE_DEFINES_SVH
`define STABLE_PRIORITY_QUEUE_DEFINES_SVH

`ifndef SYNTH

`define SPQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`define SPQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SPQ_ASSERT_IMP(lbl, ante, cons, msg)

`define SPQ_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/spq_pkg.sv =====
// Types and constants shared by the stable priority queue modules.
`default_nettype none

package spq_pkg;

  localparam int CAPACITY_DEF      = 16;
  localparam int PRIORITY_BITS_DEF = 8;
  localparam int DATA_W            = 32;
  localparam int PRIO_IN_W         = 8;
  localparam int OCC_W             = 5;

  typedef enum logic {
    REQ_ENQ = 1'b0,
    REQ_DEQ = 1'b1
  } req_type_t;

  typedef enum logic [1:0] {
    ST_ENQ   = 2'd0,
    ST_DEQ   = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef struct packed {
    req_type_t                req_type;
    logic signed [DATA_W-1:0] data_value;
    logic [PRIO_IN_W-1:0]     priority_req;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_data;
    status_t                  status;
    logic [OCC_W-1:0]         occupancy;
  } rsp_t;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic enq;
    logic deq;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/spq_cell.sv =====
// One storage cell of the sorted register chain.
`default_nettype none

module spq_cell #(
  parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire spq_pkg::cell_ctl_t               ctl,
  input  wire logic                             occupied,
  input  wire logic signed [spq_pkg::DATA_W-1:0] new_data,
  input  wire logic [PRIORITY_BITS-1:0]         new_prio,
  input  wire logic                             left_ge,
  input  wire logic signed [spq_pkg::DATA_W-1:0] left_data,
  input  wire logic [PRIORITY_BITS-1:0]         left_prio,
  input  wire logic signed [spq_pkg::DATA_W-1:0] right_data,
  input  wire logic [PRIORITY_BITS-1:0]         right_prio,
  output logic signed [spq_pkg::DATA_W-1:0]     data,
  output logic [PRIORITY_BITS-1:0]              prio,
  output logic                                  ge
);

  logic signed [spq_pkg::DATA_W-1:0] data_next;
  logic [PRIORITY_BITS-1:0]          prio_next;

  // Stored entry stays ahead of the new one.
  assign ge = occupied && (prio >= new_prio);

  always_comb begin
    data_next = data;
    prio_next = prio;
    if (ctl.enq) begin
      if (!ge) begin
        if (left_ge) begin
          data_next = new_data;
          prio_next = new_prio;
        end else begin
          data_next = left_data;
          prio_next = left_prio;
        end
      end
    end else if (ctl.deq) begin
      data_next = right_data;
      prio_next = right_prio;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
    prio <= prio_next;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/stable_priority_queue.sv =====
// Top level of the stable priority queue: cell chain, fill count, result register.
//
//   channel   dir  handshake              payload
//   req       in   req_valid / req_ready  spq_pkg::req_t
//   rsp       out  rsp_valid / rsp_ready  spq_pkg::rsp_t
//
// One request per cycle while req_ready is high; its result appears in rsp in the next cycle.
// The cell chain compares and shifts all entries in the cycle of the transfer.
// req_ready is low only while a result waits in the register and rsp_ready is low.
// Reset (rst) clears the fill count and rsp_valid; cell contents and rsp data are left as is.
`default_nettype none

`include "stable_priority_queue_defines.svh"

module stable_priority_queue #(
  parameter int CAPACITY      = spq_pkg::CAPACITY_DEF,
  parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire spq_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output spq_pkg::rsp_t      rsp
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic               rsp_valid_next;
  spq_pkg::rsp_t      rsp_next;
  spq_pkg::cell_ctl_t ctl;

  logic                              req_xfer;
  logic                              full;
  logic                              empty;
  logic [PRIORITY_BITS-1:0]          new_prio;

  logic signed [spq_pkg::DATA_W-1:0] cell_data [CAPACITY];
  logic [PRIORITY_BITS-1:0]          cell_prio [CAPACITY];
  logic                              cell_ge   [CAPACITY];

  assign req_ready = !rsp_valid || rsp_ready;
  assign req_xfer  = req_valid && req_ready;
  assign full      = (count == CNT_W'(CAPACITY));
  assign empty     = (count == '0);
  assign new_prio  = PRIORITY_BITS'(req.priority_req);

  assign ctl.enq = req_xfer && (req.req_type == spq_pkg::REQ_ENQ) && !full;
  assign ctl.deq = req_xfer && (req.req_type == spq_pkg::REQ_DEQ) && !empty;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                              left_ge;
    logic signed [spq_pkg::DATA_W-1:0] left_data;
    logic [PRIORITY_BITS-1:0]          left_prio;
    logic signed [spq_pkg::DATA_W-1:0] right_data;
    logic [PRIORITY_BITS-1:0]          right_prio;

    if (i == 0) begin : g_head
      assign left_ge   = 1'b1;
      assign left_data = req.data_value;
      assign left_prio = new_prio;
    end else begin : g_body
      assign left_ge   = cell_ge[i-1];
      assign left_data = cell_data[i-1];
      assign left_prio = cell_prio[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_data = cell_data[i];
      assign right_prio = cell_prio[i];
    end else begin : g_mid
      assign right_data = cell_data[i+1];
      assign right_prio = cell_prio[i+1];
    end

    spq_cell #(
      .PRIORITY_BITS(PRIORITY_BITS)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occupied  (CNT_W'(i) < count),
      .new_data  (req.data_value),
      .new_prio  (new_prio),
      .left_ge   (left_ge),
      .left_data (left_data),
      .left_prio (left_prio),
      .right_data(right_data),
      .right_prio(right_prio),
      .data      (cell_data[i]),
      .prio      (cell_prio[i]),
      .ge        (cell_ge[i])
    );
  end

  always_comb begin
    count_next = count;
    if (ctl.enq) begin
      count_next = count + CNT_W'(1);
    end else if (ctl.deq) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_comb begin
    rsp_next.result_data = '0;
    rsp_next.status      = spq_pkg::ST_ENQ;
    if (req.req_type == spq_pkg::REQ_DEQ) begin
      if (empty) begin
        rsp_next.result_data = '1;
        rsp_next.status      = spq_pkg::ST_EMPTY;
      end else begin
        rsp_next.result_data = cell_data[0];
        rsp_next.status      = spq_pkg::ST_DEQ;
      end
    end else if (full) begin
      rsp_next.status = spq_pkg::ST_FULL;
    end
    rsp_next.occupancy = spq_pkg::OCC_W'(count_next);
  end

  always_comb begin
    rsp_valid_next = rsp_valid;
    if (req_xfer) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_ready) begin
      rsp_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count     <= count_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (req_xfer) begin
      rsp <= rsp_next;
    end
  end

  `SPQ_ASSERT_IMP(a_count_bound, 1'b1, count <= CNT_W'(CAPACITY), "fill count above capacity")
  `SPQ_ASSERT_NXT(a_enq_grows, ctl.enq, count == $past(count) + CNT_W'(1), "enqueue lost")
  `SPQ_ASSERT_IMP(a_front_order, count >= CNT_W'(2), cell_prio[0] >= cell_prio[1], "head unsorted")
  `SPQ_ASSERT_IMP(a_empty_data, rsp_valid && (rsp.status == spq_pkg::ST_EMPTY),
                  rsp.result_data == -32'sd1, "empty dequeue data")
  `SPQ_ASSERT_NXT(a_full_keeps, req_xfer && full && (req.req_type == spq_pkg::REQ_ENQ),
                  count == CNT_W'(CAPACITY), "full enqueue changed count")

endmodule

`default_nettype wire
